[sv/kcst_pkg.sv]
package kcst_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IN_W = 144;
	localparam int OUT_W = 360;
	localparam int DIV_STEPS = 48;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] calls;
		logic [47:0] total;
		logic [31:0] min_us;
		logic [31:0] max_us;
		logic [47:0] allocated;
		logic [47:0] freed;
	} slot_rec_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? {48{1'b1}} : s[47:0];
	endfunction

	function automatic logic [31:0] sat_inc32(input logic [31:0] a);
		return (&a) ? a : a + 32'd1;
	endfunction

endpackage

[sv/kcst_cell.sv]
module kcst_cell (
	input  logic               clk,
	input  logic               shift,
	input  kcst_pkg::slot_rec_t rec_in,
	output kcst_pkg::slot_rec_t rec_out
);
	import kcst_pkg::*;

	slot_rec_t rec_q;

	// One table slot; the ring moves every slot one place toward the head per shift.
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= rec_in;
		end
	end

	assign rec_out = rec_q;

endmodule

[sv/kcst_div.sv]
module kcst_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import kcst_pkg::*;

	logic [31:0]       rem_q;
	logic [47:0]       quo_q;
	logic [31:0]       dsor_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [32:0]       trial;
	logic [32:0]       sh;

	assign sh = {rem_q, quo_q[47]};
	assign trial = sh - {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsor_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= sh[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = (|quo_q[47:32]) ? {32{1'b1}} : quo_q[31:0];

endmodule

[sv/keyed_call_statistics_table.sv]
// Keyed call statistics table.
// Input stream s_*: one call event per transaction (key, duration, signed
// allocation change, memory sample). Output stream m_*: one statistics record
// per event taken while enable is set; events taken while enable is clear vanish.
// Configuration: cfg_we with cfg_wdata writes the enable bit.
// The slots sit in a ring of cells; an event rotates the whole ring once,
// one slot per cycle past the head, where the key is matched or a new slot
// is claimed. The average then comes from a bit-serial divider of 48 steps.
// An event goes through the scan, then through the divider when a slot was
// matched or claimed, or straight to the output when the table is full;
// s_tready is high only while no event is in work, so a new event is not
// taken before the last is done. The finished result sits in an output
// register, so the next event can be accepted while the receiver stalls;
// that event completes and then waits until the register is free.
// Reset clears the enable bit, the used slot count, the global call count,
// the peak and the output valid. Slot contents need no clearing.
module keyed_call_statistics_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// call_key, duration_us, mem_change, mem_sample
	input  logic [kcst_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// entry_index, calls, total_us, min_us, max_us, avg_us, bytes_allocated,
	// bytes_freed, all_calls, peak_memory, two zero bits
	output logic [kcst_pkg::OUT_W-1:0]  m_tdata,
	// table_full
	output logic                        m_tuser
);
	import kcst_pkg::*;

	state_t     state_q;
	logic       enable_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] t_q;
	logic [31:0] gcalls_q;
	logic [47:0] peak_q;
	logic [31:0] key_q, dur_q, delta_q;
	logic        found_q;
	slot_rec_t   res_q;
	logic [IDX_W-1:0] slot_q;
	logic [31:0] avg_q;

	slot_rec_t cell_rec [ENTRIES];
	slot_rec_t head, upd, fresh, head_new;
	logic      shift, hit_match, hit_alloc, hit, last;
	logic [31:0] mag;
	logic      neg;
	logic      div_start, div_done;
	logic [31:0] div_q;
	logic      accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign shift = (state_q == ST_SCAN);
	assign head = cell_rec[0];
	assign last = (t_q == CNT_W'(ENTRIES - 1));

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			kcst_cell u_cell (
				.clk(clk),
				.shift(shift),
				.rec_in((g == ENTRIES - 1) ? head_new : cell_rec[(g + 1) % ENTRIES]),
				.rec_out(cell_rec[g])
			);
		end
	endgenerate

	always_comb begin
		neg = delta_q[31];
		mag = 32'd0 - delta_q;
		upd = head;
		upd.calls = sat_inc32(head.calls);
		upd.total = sat_add48(head.total, {16'd0, dur_q});
		if (dur_q < head.min_us) upd.min_us = dur_q;
		if (dur_q > head.max_us) upd.max_us = dur_q;
		if (neg) begin
			upd.freed = sat_add48(head.freed, {16'd0, mag});
		end else begin
			upd.allocated = sat_add48(head.allocated, {16'd0, delta_q});
		end
		fresh.key = key_q;
		fresh.calls = 32'd1;
		fresh.total = {16'd0, dur_q};
		fresh.min_us = dur_q;
		fresh.max_us = dur_q;
		fresh.allocated = neg ? 48'd0 : {16'd0, delta_q};
		fresh.freed = neg ? {16'd0, mag} : 48'd0;
		hit_match = shift && !found_q && (t_q < used_q) && (head.key == key_q);
		hit_alloc = shift && !found_q && (t_q == used_q);
		hit = hit_match || hit_alloc;
		head_new = hit_match ? upd : (hit_alloc ? fresh : head);
	end

	assign div_start = shift && last && (found_q || hit);

	kcst_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(hit ? head_new.total : res_q.total),
		.divisor(hit ? head_new.calls : res_q.calls),
		.done(div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			enable_q <= 1'b0;
			used_q <= '0;
			t_q <= '0;
			gcalls_q <= '0;
			peak_q <= '0;
			found_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) enable_q <= cfg_wdata;
			if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && enable_q) begin
						gcalls_q <= sat_inc32(gcalls_q);
						if (s_tdata[143:96] > peak_q) peak_q <= s_tdata[143:96];
						t_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					t_q <= t_q + 1'b1;
					if (hit) found_q <= 1'b1;
					if (hit_alloc) used_q <= used_q + 1'b1;
					if (last) state_q <= (found_q || hit) ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= s_tdata[31:0];
			dur_q <= s_tdata[63:32];
			delta_q <= s_tdata[95:64];
		end
		if (hit) begin
			res_q <= head_new;
			slot_q <= t_q[IDX_W-1:0];
		end
		if (state_q == ST_DIV && div_done) avg_q <= div_q;
		if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
			m_tuser <= !found_q;
			m_tdata[359:358] <= 2'b00;
			m_tdata[357:310] <= peak_q;
			m_tdata[309:278] <= gcalls_q;
			if (found_q) begin
				m_tdata[5:0] <= 6'(slot_q);
				m_tdata[37:6] <= res_q.calls;
				m_tdata[85:38] <= res_q.total;
				m_tdata[117:86] <= res_q.min_us;
				m_tdata[149:118] <= res_q.max_us;
				m_tdata[181:150] <= avg_q;
				m_tdata[229:182] <= res_q.allocated;
				m_tdata[277:230] <= res_q.freed;
			end else begin
				m_tdata[277:0] <= '0;
			end
		end
	end

endmodule

[sv/kcst_chk.sv]
module kcst_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [kcst_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[277:0] == '0)
		else $error("full table result carries slot fields");

	a_calls_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[37:6] != 32'd0 && m_tdata[309:278] != 32'd0)
		else $error("slot result with zero call count");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[117:86] <= m_tdata[149:118])
		else $error("minimum above maximum");

endmodule

bind keyed_call_statistics_table kcst_chk u_kcst_chk (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import kcst_pkg::*;

	localparam int SLOTS = ENTRIES;
	localparam int DRAIN_CYCLES = 160;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int KEY_POOL = 80;
	localparam logic [47:0] ALL48 = {48{1'b1}};
	localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

	// Same layout as m_tdata, highest field first.
	typedef struct packed {
		logic [1:0]  pad;
		logic [47:0] peak_memory;
		logic [31:0] all_calls;
		logic [47:0] bytes_freed;
		logic [47:0] bytes_allocated;
		logic [31:0] avg_us;
		logic [31:0] max_us;
		logic [31:0] min_us;
		logic [47:0] total_us;
		logic [31:0] calls;
		logic [5:0]  entry_index;
	} call_stats_t;

	typedef struct packed {
		call_stats_t rec;
		logic        full;
	} stats_result_t;

	typedef struct {
		logic [31:0] key;
		logic [31:0] dur;
		logic [31:0] delta;
		logic [47:0] mem;
		bit          typed;
		logic [5:0]  idx;
		logic [31:0] calls;
	} event_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	keyed_call_statistics_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Shadow copy of the statistics table.
	logic [31:0] sh_key [SLOTS];
	logic [31:0] sh_calls [SLOTS];
	logic [47:0] sh_total [SLOTS];
	logic [31:0] sh_min [SLOTS];
	logic [31:0] sh_max [SLOTS];
	logic [47:0] sh_alloc [SLOTS];
	logic [47:0] sh_freed [SLOTS];
	int unsigned sh_used;
	logic [31:0] sh_global;
	logic [47:0] sh_peak;
	bit          sh_enable;

	stats_result_t pending_stats[$];
	logic [31:0]   key_pool [KEY_POOL];
	int  errors = 0;
	int  records_seen = 0;
	int  full_seen = 0;
	int  idle_pct;
	int  stall_pct;
	int  quiet_cycles = 0;
	bit  pin_typed;
	logic [5:0]  pin_idx;
	logic [31:0] pin_calls;

	function automatic logic [47:0] add_clamp48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? ALL48 : s[47:0];
	endfunction

	function automatic logic [31:0] inc_clamp32(input logic [31:0] a);
		return (a == ALL32) ? a : a + 32'd1;
	endfunction

	// Applies one event to the shadow table; returns 1 if a record is due.
	function automatic bit record_call(input logic [31:0] key, input logic [31:0] dur,
			input logic [31:0] delta, input logic [47:0] mem, output stats_result_t r);
		int  slot;
		bit  hit;
		logic [32:0] mag;
		logic [47:0] avg;
		slot = 0;
		hit = 0;
		r = '0;
		if (!sh_enable)
			return 0;
		for (int i = 0; i < sh_used; i++) begin
			if (!hit && sh_key[i] == key) begin
				slot = i;
				hit = 1;
			end
		end
		if (!hit && sh_used < SLOTS) begin
			slot = sh_used;
			sh_used++;
			sh_key[slot] = key;
			sh_calls[slot] = '0;
			sh_total[slot] = '0;
			sh_min[slot] = dur;
			sh_max[slot] = dur;
			sh_alloc[slot] = '0;
			sh_freed[slot] = '0;
			hit = 1;
		end
		sh_global = inc_clamp32(sh_global);
		if (mem > sh_peak)
			sh_peak = mem;
		r.rec.all_calls = sh_global;
		r.rec.peak_memory = sh_peak;
		if (!hit) begin
			r.full = 1'b1;
			return 1;
		end
		sh_calls[slot] = inc_clamp32(sh_calls[slot]);
		sh_total[slot] = add_clamp48(sh_total[slot], {16'd0, dur});
		if (dur < sh_min[slot])
			sh_min[slot] = dur;
		if (dur > sh_max[slot])
			sh_max[slot] = dur;
		if (delta[31]) begin
			mag = 33'h1_0000_0000 - {1'b0, delta};
			sh_freed[slot] = add_clamp48(sh_freed[slot], {15'd0, mag});
		end else if (delta != 0) begin
			sh_alloc[slot] = add_clamp48(sh_alloc[slot], {16'd0, delta});
		end
		avg = sh_total[slot] / {16'd0, sh_calls[slot]};
		r.rec.entry_index = slot[5:0];
		r.rec.calls = sh_calls[slot];
		r.rec.total_us = sh_total[slot];
		r.rec.min_us = sh_min[slot];
		r.rec.max_us = sh_max[slot];
		r.rec.avg_us = (avg > {16'd0, ALL32}) ? ALL32 : avg[31:0];
		r.rec.bytes_allocated = sh_alloc[slot];
		r.rec.bytes_freed = sh_freed[slot];
		return 1;
	endfunction

	task automatic check_field(input string name, input logic [47:0] exp_v,
			input logic [47:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: random stall on m_tready and compare each record taken.
	always @(posedge clk) begin
		call_stats_t got;
		stats_result_t want;
		if (m_tvalid && m_tready && arst_n) begin
			got = m_tdata;
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected record, actual %h", $realtime, m_tdata);
				errors++;
			end else begin
				want = pending_stats.pop_front();
				records_seen++;
				if (m_tuser)
					full_seen++;
				check_field("table_full", 48'(want.full), 48'(m_tuser));
				check_field("entry_index", 48'(want.rec.entry_index),
					48'(got.entry_index));
				check_field("calls", 48'(want.rec.calls), 48'(got.calls));
				check_field("total_us", want.rec.total_us, got.total_us);
				check_field("min_us", 48'(want.rec.min_us), 48'(got.min_us));
				check_field("max_us", 48'(want.rec.max_us), 48'(got.max_us));
				check_field("avg_us", 48'(want.rec.avg_us), 48'(got.avg_us));
				check_field("bytes_allocated", want.rec.bytes_allocated,
					got.bytes_allocated);
				check_field("bytes_freed", want.rec.bytes_freed, got.bytes_freed);
				check_field("all_calls", 48'(want.rec.all_calls), 48'(got.all_calls));
				check_field("peak_memory", want.rec.peak_memory, got.peak_memory);
				check_field("padding", 48'd0, 48'(got.pad));
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on cycles in which neither stream moves a transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_enable(input bit value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_enable = value;
	endtask

	task automatic send_call(input logic [31:0] key, input logic [31:0] dur,
			input logic [31:0] delta, input logic [47:0] mem);
		stats_result_t r;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {mem, delta, dur, key};
		do
			@(posedge clk);
		while (!s_tready);
		if (record_call(key, dur, delta, mem, r)) begin
			if (pin_typed) begin
				r.rec.entry_index = pin_idx;
				r.rec.calls = pin_calls;
			end
			pending_stats.push_back(r);
		end
		pin_typed = 0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_dur();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return ALL32;
			2: return $urandom_range(1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_delta();
		case ($urandom_range(6))
			0: return 32'd0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(4096);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] pick_mem();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(7))
			0: return 48'd0;
			1: return ALL48;
			default: return w[47:0];
		endcase
	endfunction

	event_row_t directed[] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 48'h0, 1, 6'd0, 32'd1},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'h0, 1, 6'd0, 32'd2},
		'{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1, 6'd1, 32'd1},
		'{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 48'h0, 1, 6'd1, 32'd2},
		'{32'h1234_5678, 32'd1000, 32'hFFFF_F000, 48'd1234, 1, 6'd2, 32'd1},
		'{32'h0000_0000, 32'd7, 32'h0000_0000, 48'd5, 0, 6'd0, 32'd0},
		'{32'h1234_5678, 32'd999999, 32'd100, 48'd99, 0, 6'd0, 32'd0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555, 0, 6'd0, 32'd0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 0, 6'd0, 32'd0},
		'{32'hAAAA_AAAA, 32'h0000_0003, 32'h8000_0000, 48'h0, 0, 6'd0, 32'd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 48'h0, 0, 6'd0, 32'd0},
		'{32'h1234_5678, 32'd0, 32'h0000_0000, 48'd1, 0, 6'd0, 32'd0}
	};

	initial begin
		int idle_set[4] = '{0, 51, 0, 21};
		int stall_set[4] = '{0, 0, 51, 21};
		logic [31:0] k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		pin_typed = 0;
		sh_used = 0;
		sh_global = '0;
		sh_peak = '0;
		sh_enable = 0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Recording is off after reset, so these events must vanish.
		for (int i = 0; i < 3; i++)
			send_call($urandom, pick_dur(), pick_delta(), pick_mem());
		settle();
		write_enable(1'b0);
		write_enable(1'b1);

		foreach (directed[i]) begin
			pin_typed = directed[i].typed;
			pin_idx = directed[i].idx;
			pin_calls = directed[i].calls;
			send_call(directed[i].key, directed[i].dur, directed[i].delta, directed[i].mem);
		end

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Mostly repeat keys from a pool larger than the table, so
				// slots fill up and later unknown keys hit the full case.
				if ($urandom_range(9) < 8)
					k = key_pool[$urandom_range(KEY_POOL - 1)];
				else
					k = $urandom;
				send_call(k, pick_dur(), pick_delta(), pick_mem());
			end
			settle();
			if (ph == 1) begin
				write_enable(1'b0);
				for (int i = 0; i < 8; i++)
					send_call(key_pool[i], pick_dur(), pick_delta(), pick_mem());
				settle();
				write_enable(1'b1);
			end
		end

		$display("Checked %0d statistics records (%0d with the table full), %0d slots used,",
			records_seen, full_seen, sh_used);
		$display("with recording switched off and on and four idle/stall mixes.");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
